// File: sv/rpn_pkg.sv
package rpn_pkg;

   // stack depth default and fixed field widths
   localparam int DEF_STACK_DEPTH = 32;
   localparam int DATA_W          = 32;
   localparam int DIV_CNT_W       = 5;
   localparam int UPC_W           = 5;

   // token codes
   typedef enum logic [2:0] {
      TOK_PUSH = 3'd0,
      TOK_NEG  = 3'd1,
      TOK_ADD  = 3'd2,
      TOK_SUB  = 3'd3,
      TOK_MUL  = 3'd4,
      TOK_DIV  = 3'd5,
      TOK_MOD  = 3'd6,
      TOK_END  = 3'd7
   } tok_type;

   // status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DIV0  = 2'd1,
      ST_OVF   = 2'd2,
      ST_STACK = 2'd3
   } status_type;

   // request and response payloads
   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] operand_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } rsp_payload_type;

   // microcode sequencing
   typedef enum logic [2:0] {
      J_NEXT,
      J_ALWAYS,
      J_IF,
      J_DISPATCH,
      J_WAIT_DIV,
      J_WAIT_OUT
   } jump_type;

   typedef enum logic [2:0] {
      FL_ERR,
      FL_FULL,
      FL_EMPTY,
      FL_LT2,
      FL_DIVOP,
      FL_RZERO,
      FL_OVF
   } flag_sel_type;

   // datapath selects
   typedef enum logic [1:0] {
      RD_TOP,
      RD_NEXT,
      RD_BOTTOM
   } rd_sel_type;

   typedef enum logic [1:0] {
      WA_LEVEL,
      WA_TOP,
      WA_NEXT
   } wr_sel_type;

   typedef enum logic {
      WS_VALUE,
      WS_RES
   } wr_src_type;

   typedef enum logic {
      A_TOK,
      A_NEG
   } alu_sel_type;

   typedef enum logic [1:0] {
      LV_HOLD,
      LV_INC,
      LV_DEC
   } lvl_op_type;

   // controls from sequencer to datapath
   typedef struct packed {
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        ld_l;
      logic        ld_r;
      logic        alu_en;
      alu_sel_type alu_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      wr_src_type  wr_src;
      lvl_op_type  lvl_op;
      logic        err_set;
      status_type  err_code;
      logic        div_start;
      logic        emit;
   } ctl_type;

   // status from datapath to sequencer
   typedef struct packed {
      logic err;
      logic full;
      logic empty;
      logic lt2;
      logic divop;
      logic rzero;
      logic ovf;
      logic div_busy;
      logic out_busy;
   } flags_type;

   // one control word
   typedef struct packed {
      jump_type           jmp;
      flag_sel_type       flag;
      logic [UPC_W-1:0]   target;
      logic               accept;
      ctl_type            ctl;
   } uword_type;

   // microprogram entry points
   localparam logic [UPC_W-1:0] U_IDLE     = 5'd0;
   localparam logic [UPC_W-1:0] U_PUSH     = 5'd1;
   localparam logic [UPC_W-1:0] U_NEG      = 5'd4;
   localparam logic [UPC_W-1:0] U_BIN      = 5'd10;
   localparam logic [UPC_W-1:0] U_BIN_CMT  = 5'd16;
   localparam logic [UPC_W-1:0] U_DIVR     = 5'd18;
   localparam logic [UPC_W-1:0] U_ERR_STK  = 5'd21;
   localparam logic [UPC_W-1:0] U_ERR_OVF  = 5'd22;
   localparam logic [UPC_W-1:0] U_ERR_DIV0 = 5'd23;
   localparam logic [UPC_W-1:0] U_END      = 5'd24;

   // dispatch table: token code to routine entry
   function automatic logic [UPC_W-1:0] entry_of(input logic [2:0] code);
      logic [UPC_W-1:0] e;
      case (tok_type'(code))
         TOK_PUSH: e = U_PUSH;
         TOK_NEG:  e = U_NEG;
         TOK_END:  e = U_END;
         default:  e = U_BIN;
      endcase
      return e;
   endfunction

   // microprogram rom
   function automatic uword_type ucode(input logic [UPC_W-1:0] upc);
      uword_type w;
      w = '0;
      case (upc)
         // wait for a request
         5'd0: begin
            w.jmp    = J_DISPATCH;
            w.accept = 1'b1;
         end
         // push
         5'd1: begin
            w.jmp = J_IF; w.flag = FL_ERR; w.target = U_IDLE;
         end
         5'd2: begin
            w.jmp = J_IF; w.flag = FL_FULL; w.target = U_ERR_STK;
         end
         5'd3: begin
            w.jmp = J_ALWAYS; w.target = U_IDLE;
            w.ctl.wr_en = 1'b1; w.ctl.wr_sel = WA_LEVEL; w.ctl.wr_src = WS_VALUE;
            w.ctl.lvl_op = LV_INC;
         end
         // negate top
         5'd4: begin
            w.jmp = J_IF; w.flag = FL_ERR; w.target = U_IDLE;
         end
         5'd5: begin
            w.jmp = J_IF; w.flag = FL_EMPTY; w.target = U_ERR_STK;
            w.ctl.rd_en = 1'b1; w.ctl.rd_sel = RD_TOP;
         end
         5'd6: begin
            w.ctl.ld_r = 1'b1;
         end
         5'd7: begin
            w.ctl.alu_en = 1'b1; w.ctl.alu_sel = A_NEG;
         end
         5'd8: begin
            w.jmp = J_IF; w.flag = FL_OVF; w.target = U_ERR_OVF;
         end
         5'd9: begin
            w.jmp = J_ALWAYS; w.target = U_IDLE;
            w.ctl.wr_en = 1'b1; w.ctl.wr_sel = WA_TOP; w.ctl.wr_src = WS_RES;
         end
         // binary operations
         5'd10: begin
            w.jmp = J_IF; w.flag = FL_ERR; w.target = U_IDLE;
         end
         5'd11: begin
            w.jmp = J_IF; w.flag = FL_LT2; w.target = U_ERR_STK;
            w.ctl.rd_en = 1'b1; w.ctl.rd_sel = RD_NEXT;
         end
         5'd12: begin
            w.ctl.ld_l = 1'b1;
            w.ctl.rd_en = 1'b1; w.ctl.rd_sel = RD_TOP;
         end
         5'd13: begin
            w.ctl.ld_r = 1'b1;
         end
         5'd14: begin
            w.jmp = J_IF; w.flag = FL_DIVOP; w.target = U_DIVR;
         end
         5'd15: begin
            w.ctl.alu_en = 1'b1; w.ctl.alu_sel = A_TOK;
         end
         5'd16: begin
            w.jmp = J_IF; w.flag = FL_OVF; w.target = U_ERR_OVF;
         end
         5'd17: begin
            w.jmp = J_ALWAYS; w.target = U_IDLE;
            w.ctl.wr_en = 1'b1; w.ctl.wr_sel = WA_NEXT; w.ctl.wr_src = WS_RES;
            w.ctl.lvl_op = LV_DEC;
         end
         // divide and modulo
         5'd18: begin
            w.jmp = J_IF; w.flag = FL_RZERO; w.target = U_ERR_DIV0;
            w.ctl.div_start = 1'b1;
         end
         5'd19: begin
            w.jmp = J_WAIT_DIV;
         end
         5'd20: begin
            w.jmp = J_ALWAYS; w.target = U_BIN_CMT;
            w.ctl.alu_en = 1'b1; w.ctl.alu_sel = A_TOK;
         end
         // error latching
         5'd21: begin
            w.jmp = J_ALWAYS; w.target = U_IDLE;
            w.ctl.err_set = 1'b1; w.ctl.err_code = ST_STACK;
         end
         5'd22: begin
            w.jmp = J_ALWAYS; w.target = U_IDLE;
            w.ctl.err_set = 1'b1; w.ctl.err_code = ST_OVF;
         end
         5'd23: begin
            w.jmp = J_ALWAYS; w.target = U_IDLE;
            w.ctl.err_set = 1'b1; w.ctl.err_code = ST_DIV0;
         end
         // end of expression
         5'd24: begin
            w.ctl.rd_en = 1'b1; w.ctl.rd_sel = RD_BOTTOM;
         end
         5'd25: begin
            w.jmp = J_WAIT_OUT; w.target = U_IDLE;
            w.ctl.emit = 1'b1;
         end
         default: begin
            w.jmp = J_ALWAYS; w.target = U_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: sv/rpn_div.sv
module rpn_div
   import rpn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              busy,
   output logic [DATA_W-1:0] quot,
   output logic [DATA_W-1:0] rem
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    dsr_ff, dsr_in;
   logic [DATA_W:0]      trial;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

// File: sv/rpn_dpath.sv
module rpn_dpath
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_fire,
   input  req_payload_type req_payload,
   input  ctl_type         ctl,
   output flags_type       flags,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [DATA_W-1:0] INT_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] MINUS_ONE = '1;

   // operand stack
   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [DATA_W-1:0] wr_data;

   logic [LVL_W-1:0]  level_ff, level_in;
   logic [LVL_W-1:0]  lvl_m1, lvl_m2;
   status_type        err_ff, err_in;

   logic [2:0]         tok_ff;
   logic [DATA_W-1:0]  val_ff;
   logic signed [DATA_W-1:0] l_ff, r_ff;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic [DATA_W-1:0]  res_ff, res_in;
   logic               ovf_ff, ovf_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic [DATA_W:0]    sum, diff;
   logic [DATA_W-1:0]  l_mag, r_mag;
   logic [DATA_W-1:0]  q_mag, r_rem;
   logic               div_busy;
   logic               div_go;
   status_type         end_status;

   // stack addresses
   assign lvl_m1 = level_ff - LVL_W'(1);
   assign lvl_m2 = level_ff - LVL_W'(2);

   always_comb begin
      case (ctl.rd_sel)
         RD_TOP:  rd_addr = lvl_m1[ADDR_W-1:0];
         RD_NEXT: rd_addr = lvl_m2[ADDR_W-1:0];
         default: rd_addr = '0;
      endcase
      case (ctl.wr_sel)
         WA_LEVEL: wr_addr = level_ff[ADDR_W-1:0];
         WA_TOP:   wr_addr = lvl_m1[ADDR_W-1:0];
         default:  wr_addr = lvl_m2[ADDR_W-1:0];
      endcase
      wr_data = (ctl.wr_src == WS_VALUE) ? val_ff : res_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // divider on magnitudes, only started for a nonzero divisor
   assign l_mag  = l_ff[DATA_W-1] ? (DATA_W'(0) - l_ff) : l_ff;
   assign r_mag  = r_ff[DATA_W-1] ? (DATA_W'(0) - r_ff) : r_ff;
   assign div_go = ctl.div_start && (r_ff != '0);

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (l_mag),
      .divisor  (r_mag),
      .busy     (div_busy),
      .quot     (q_mag),
      .rem      (r_rem)
   );

   // alu
   assign sum  = {l_ff[DATA_W-1], l_ff} + {r_ff[DATA_W-1], r_ff};
   assign diff = {l_ff[DATA_W-1], l_ff} - {r_ff[DATA_W-1], r_ff};

   always_comb begin
      res_in = res_ff;
      ovf_in = ovf_ff;
      if (ctl.alu_en) begin
         if (ctl.alu_sel == A_NEG) begin
            res_in = DATA_W'(0) - r_ff;
            ovf_in = (r_ff == INT_MIN);
         end else begin
            case (tok_type'(tok_ff))
               TOK_SUB: begin
                  res_in = diff[DATA_W-1:0];
                  ovf_in = diff[DATA_W] ^ diff[DATA_W-1];
               end
               TOK_MUL: begin
                  res_in = prod_ff[DATA_W-1:0];
                  ovf_in = !((&prod_ff[2*DATA_W-1:DATA_W-1]) ||
                             !(|prod_ff[2*DATA_W-1:DATA_W-1]));
               end
               TOK_DIV: begin
                  res_in = (l_ff[DATA_W-1] ^ r_ff[DATA_W-1]) ? (DATA_W'(0) - q_mag) : q_mag;
                  ovf_in = (l_ff == INT_MIN) && (r_ff == MINUS_ONE);
               end
               TOK_MOD: begin
                  res_in = l_ff[DATA_W-1] ? (DATA_W'(0) - r_rem) : r_rem;
                  ovf_in = 1'b0;
               end
               default: begin
                  res_in = sum[DATA_W-1:0];
                  ovf_in = sum[DATA_W] ^ sum[DATA_W-1];
               end
            endcase
         end
      end
   end

   // status and level update
   always_comb begin
      level_in = level_ff;
      err_in   = err_ff;
      case (ctl.lvl_op)
         LV_INC:  level_in = level_ff + LVL_W'(1);
         LV_DEC:  level_in = lvl_m1;
         default: level_in = level_ff;
      endcase
      if (ctl.err_set) begin
         err_in = ctl.err_code;
      end
      if (ctl.emit) begin
         level_in = '0;
         err_in   = ST_OK;
      end
   end

   // response register
   always_comb begin
      if (err_ff != ST_OK) begin
         end_status = err_ff;
      end else if (level_ff == '0) begin
         end_status = ST_STACK;
      end else begin
         end_status = ST_OK;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (ctl.emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = end_status;
         rsp_in.result_value = (end_status == ST_OK) ? rd_data_ff : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         tok_ff <= req_payload.req_type;
         val_ff <= req_payload.operand_value;
      end
      if (ctl.ld_l) begin
         l_ff <= rd_data_ff;
      end
      if (ctl.ld_r) begin
         r_ff <= rd_data_ff;
      end
      prod_ff <= l_ff * r_ff;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
      rsp_ff  <= rsp_in;
   end

   // flags to the sequencer
   always_comb begin
      flags.err      = (err_ff != ST_OK);
      flags.full     = (level_ff == LVL_W'(STACK_DEPTH));
      flags.empty    = (level_ff == '0);
      flags.lt2      = (level_ff < LVL_W'(2));
      flags.divop    = (tok_ff == TOK_DIV) || (tok_ff == TOK_MOD);
      flags.rzero    = (r_ff == '0);
      flags.ovf      = ovf_ff;
      flags.div_busy = div_busy;
      flags.out_busy = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // level stays within the stack
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(STACK_DEPTH))
      else $error("stack level beyond depth");

   // a push write never lands past the top
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_en && ctl.wr_sel == WA_LEVEL) |-> !flags.full)
      else $error("push into full stack");

   // a result is never emitted over one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overwritten");

   // divider is only started when idle
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_go |-> !div_busy)
      else $error("bad divider start");

endmodule

// File: sv/rpn_seq.sv
module rpn_seq
   import rpn_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_fire,
   input  logic [2:0] req_code,
   input  flags_type flags,
   output logic      req_stall,
   output ctl_type   ctl
);

   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type        word;
   logic             cond;
   logic             hold;

   // fetch the control word
   assign word = ucode(upc_ff);

   // condition select
   always_comb begin
      case (word.flag)
         FL_ERR:   cond = flags.err;
         FL_FULL:  cond = flags.full;
         FL_EMPTY: cond = flags.empty;
         FL_LT2:   cond = flags.lt2;
         FL_DIVOP: cond = flags.divop;
         FL_RZERO: cond = flags.rzero;
         FL_OVF:   cond = flags.ovf;
         default:  cond = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      hold = 1'b0;
      case (word.jmp)
         J_NEXT:     upc_in = upc_ff + 1'b1;
         J_ALWAYS:   upc_in = word.target;
         J_IF:       upc_in = cond ? word.target : upc_ff + 1'b1;
         J_DISPATCH: upc_in = req_fire ? entry_of(req_code) : upc_ff;
         J_WAIT_DIV: begin
            hold   = flags.div_busy;
            upc_in = hold ? upc_ff : upc_ff + 1'b1;
         end
         J_WAIT_OUT: begin
            hold   = flags.out_busy;
            upc_in = hold ? upc_ff : word.target;
         end
         default:    upc_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   // controls are suppressed while a step waits
   assign ctl       = hold ? ctl_type'('0) : word.ctl;
   assign req_stall = !word.accept;

endmodule

// File: sv/postfix_int32_evaluator.sv
// Postfix evaluator for signed 32-bit integers. Each request carries one token:
// push a value, negate the top, add, subtract, multiply, divide, modulo, or end.
// End returns the bottom stack entry with a status (0 ok, 1 divide by zero,
// 2 overflow, 3 stack fault; value zero when status is nonzero) and clears the
// stack; after an error every token but end is ignored. Tokens are run by a
// microprogram one at a time; a new request is taken only in the idle step.
// End also waits while an earlier response is still held, and divide and
// modulo run a bit-serial restoring divider. A response may wait in its output
// register while further tokens are taken.
module postfix_int32_evaluator
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic      req_fire;
   ctl_type   ctl;
   flags_type flags;

   assign req_fire = req_valid && !req_stall;

   // microcode sequencer
   rpn_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_code  (req_payload.req_type),
      .flags     (flags),
      .req_stall (req_stall),
      .ctl       (ctl)
   );

   // stack, alu and response datapath
   rpn_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_payload (req_payload),
      .ctl         (ctl),
      .flags       (flags),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/postfix_checker.sv
module postfix_checker
   import rpn_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   output int              fail_count,
   output int              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   // predicted evaluator state
   logic [31:0]     calc_stack [DEF_STACK_DEPTH];
   int unsigned     calc_depth;
   status_type      calc_status;
   rsp_payload_type pending_results [$];
   int              mismatches;

   initial begin
      mismatches  = 0;
      fail_count  = 0;
      outstanding = 0;
      calc_depth  = 0;
      calc_status = ST_OK;
   end

   function automatic void log_mismatch(input string what, input rsp_payload_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected value %0d status %0d, got value %0d status %0d",
                  $realtime, what, want.result_value, want.status,
                  rsp_payload.result_value, rsp_payload.status);
      end
   endfunction

   // apply one token to the predicted stack, queue a result on end
   function automatic void evaluate_token(input req_payload_type tok);
      longint          lhs;
      longint          rhs;
      longint          res;
      rsp_payload_type res_item;
      tok_type         kind;
      kind = tok_type'(tok.req_type);

      // end emits bottom entry and status, then clears everything
      if (kind == TOK_END) begin
         res_item.status = calc_status;
         if (calc_status == ST_OK && calc_depth == 0) begin
            res_item.status = ST_STACK;
         end
         res_item.result_value = (res_item.status == ST_OK) ? calc_stack[0] : '0;
         pending_results.push_back(res_item);
         calc_depth  = 0;
         calc_status = ST_OK;
         return;
      end

      // latched error swallows everything but end
      if (calc_status != ST_OK) begin
         return;
      end

      case (kind)
         TOK_PUSH: begin
            if (calc_depth >= DEF_STACK_DEPTH) begin
               calc_status = ST_STACK;
            end else begin
               calc_stack[calc_depth] = tok.operand_value;
               calc_depth++;
            end
         end
         TOK_NEG: begin
            if (calc_depth == 0) begin
               calc_status = ST_STACK;
            end else if (calc_stack[calc_depth-1] == 32'h8000_0000) begin
               calc_status = ST_OVF;
            end else begin
               calc_stack[calc_depth-1] = -calc_stack[calc_depth-1];
            end
         end
         default: begin
            if (calc_depth < 2) begin
               calc_status = ST_STACK;
               return;
            end
            lhs = $signed(calc_stack[calc_depth-2]);
            rhs = $signed(calc_stack[calc_depth-1]);
            if ((kind == TOK_DIV || kind == TOK_MOD) && rhs == 0) begin
               calc_status = ST_DIV0;
               return;
            end
            case (kind)
               TOK_ADD: res = lhs + rhs;
               TOK_SUB: res = lhs - rhs;
               TOK_MUL: res = lhs * rhs;
               TOK_DIV: res = lhs / rhs;
               default: res = lhs % rhs;
            endcase
            if (res > WORD_MAX || res < WORD_MIN) begin
               calc_status = ST_OVF;
               return;
            end
            calc_depth--;
            calc_stack[calc_depth-1] = res[31:0];
         end
      endcase
   endfunction

   // watch both channels at every edge
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         calc_depth  = 0;
         calc_status = ST_OK;
         pending_results.delete();
      end else begin
         // compare an accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               want = '0;
               log_mismatch("result with nothing pending", want);
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.result_value !== want.result_value ||
                   rsp_payload.status !== want.status) begin
                  log_mismatch("result mismatch", want);
               end
            end
         end
         // predict from an accepted request
         if (req_valid && !req_stall) begin
            evaluate_token(req_payload);
         end
      end
      fail_count  <= mismatches;
      outstanding <= pending_results.size();
   end

endmodule

// File: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rpn_pkg::*;

   localparam logic [31:0] WORD_MAX   = 32'h7fff_ffff;
   localparam logic [31:0] WORD_MIN   = 32'h8000_0000;
   localparam logic [31:0] MINUS_ONE  = 32'hffff_ffff;
   localparam int          RANDOM_REQUESTS = 1250;
   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          LONG_HOLD       = 400;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   int              fail_count;
   int              outstanding;
   bit              steady_mode;
   int              sent_requests;
   int              cycle_count;

   postfix_int32_evaluator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   postfix_checker calc_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // offer one request after a random gap, return once it is taken
   task automatic send_token(input tok_type kind, input logic [31:0] value);
      int gap;
      gap = steady_mode ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{req_type: kind, operand_value: value};
      do @(posedge clock); while (req_stall);
      sent_requests++;
   endtask

   // stop sending until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // operand mix weighted toward the corner values
   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = WORD_MIN;
         1:       v = WORD_MAX;
         2:       v = '0;
         3:       v = MINUS_ONE;
         4:       v = 32'd1;
         5, 6:    v = 32'($urandom_range(0, 200)) - 32'd100;
         7:       v = $urandom_range(0, 1) ? 32'($urandom_range(0, 65535))
                                           : -32'($urandom_range(0, 65535));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic tok_type pick_binop();
      return tok_type'($urandom_range(TOK_ADD, TOK_MOD));
   endfunction

   // one expression: mostly well formed, some deep, some noise
   task automatic random_expression();
      int depth;
      int choice;
      choice = $urandom_range(0, 99);
      if (choice < 4) begin
         // fill the stack to near, at or past its limit
         repeat ($urandom_range(DEF_STACK_DEPTH - 2, DEF_STACK_DEPTH + 2)) begin
            send_token(TOK_PUSH, pick_operand());
         end
         send_token(pick_binop(), $urandom);
      end else if (choice < 80) begin
         // well-formed tokens with random content
         depth = 0;
         repeat ($urandom_range(1, 10)) begin
            if (depth < 2 || ($urandom_range(0, 2) == 0 && depth < 6)) begin
               send_token(TOK_PUSH, pick_operand());
               depth++;
            end else if ($urandom_range(0, 4) == 0) begin
               send_token(TOK_NEG, $urandom);
            end else begin
               send_token(pick_binop(), $urandom);
               depth--;
            end
         end
         while (depth > 1 && $urandom_range(0, 4) != 0) begin
            send_token(pick_binop(), $urandom);
            depth--;
         end
      end else begin
         // arbitrary token soup
         repeat ($urandom_range(1, 6)) begin
            send_token(tok_type'($urandom_range(TOK_PUSH, TOK_END)), pick_operand());
         end
      end
      send_token(TOK_END, $urandom);
   endtask

   // result side: random stalls, one long hold-off
   initial begin
      int gap;
      int taken;
      rsp_stall = 1'b0;
      taken     = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == 30) begin
            gap = LONG_HOLD;
         end else if (steady_mode) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 6);
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         taken++;
      end
   end

   // request side and verdict
   initial begin
      int random_start;
      int expr_count;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      steady_mode   = 1'b0;
      sent_requests = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // extremes with multiply, two entries left
      send_token(TOK_PUSH, WORD_MAX);
      send_token(TOK_PUSH, MINUS_ONE);
      send_token(TOK_PUSH, MINUS_ONE);
      send_token(TOK_MUL, $urandom);
      send_token(TOK_END, $urandom);
      // min plus max
      send_token(TOK_PUSH, WORD_MIN);
      send_token(TOK_PUSH, WORD_MAX);
      send_token(TOK_ADD, $urandom);
      send_token(TOK_END, $urandom);
      // negating the minimum overflows
      send_token(TOK_PUSH, WORD_MIN);
      send_token(TOK_NEG, $urandom);
      send_token(TOK_END, $urandom);
      // minimum modulo minus one is zero
      send_token(TOK_PUSH, WORD_MIN);
      send_token(TOK_PUSH, MINUS_ONE);
      send_token(TOK_MOD, $urandom);
      send_token(TOK_END, $urandom);
      // divide by zero, later token ignored
      send_token(TOK_PUSH, 32'd7);
      send_token(TOK_PUSH, '0);
      send_token(TOK_DIV, $urandom);
      send_token(TOK_NEG, $urandom);
      send_token(TOK_END, $urandom);
      // negate and subtract without enough entries, end on empty
      send_token(TOK_NEG, $urandom);
      send_token(TOK_END, $urandom);
      send_token(TOK_PUSH, 32'd1);
      send_token(TOK_SUB, $urandom);
      send_token(TOK_END, $urandom);
      send_token(TOK_END, $urandom);
      wait_drained();

      // random expressions
      random_start = sent_requests;
      expr_count   = 0;
      while (sent_requests - random_start < RANDOM_REQUESTS) begin
         steady_mode <= ($urandom_range(0, 7) == 0);
         random_expression();
         expr_count++;
         if (expr_count == 60) begin
            wait_drained();
         end
      end

      // drain and let the block settle
      wait_drained();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
